// File: rtl/core/fgwr_pkg.sv
// ----------------------------------------------------------------------------
// fgwr_pkg
// Shared types and constants for the free-group word reducer: the command
// and result transaction structs, opcode and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package fgwr_pkg;

    localparam int DEPTH_DEFAULT    = 256;
    localparam int EXP_BITS_DEFAULT = 32;

    localparam int GEN_W = 16;
    localparam int POW_W = 16;
    localparam int LEN_W = 40;
    localparam int CNT_W = 9;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_QUERY      = 2'd2,
        OP_CLEAR      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [GEN_W-1:0]          generator;
        logic signed [POW_W-1:0]   power;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic [LEN_W-1:0]          word_length;
        logic [CNT_W-1:0]          run_count;
        logic signed [LEN_W-1:0]   exponent_sum;
        logic [LEN_W-1:0]          occurrence_count;
    } result_t;

endpackage

// File: rtl/core/free_group_word_reducer_core.sv
// ----------------------------------------------------------------------------
// free_group_word_reducer_core
// Free-group word held as a circular deque of (generator, exponent) runs.
// Pushes merge with the end run or open a new one, queries scan all runs
// through one shared exponent unit, and a clear empties the deque.
// ----------------------------------------------------------------------------
// Push and clear: busy in the update state, from which the result strobe is
// registered; a new transaction is taken only once the core is idle again.
// Query over R runs: busy in the scan state, one run read from the run
// memory per cycle, and the result strobe is registered after the last run.
// Reset clears pointers, run count and word length; the run memory is not
// cleared. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module free_group_word_reducer_core
    import fgwr_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEFAULT,
    parameter int EXP_BITS = EXP_BITS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = CW + 1;
    localparam int SUM_W = ((EXP_BITS > POW_W) ? EXP_BITS : POW_W) + 1;
    localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

    state_t                     state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              runs_reg, runs_next;
    logic [LEN_W-1:0]           total_reg, total_next;
    logic [CW-1:0]              scan_left_reg, scan_left_next;
    logic                       pend_reg, pend_next;
    logic                       done_reg, done_next;

    opcode_t                    op_reg, op_next;
    logic [GEN_W-1:0]           gen_reg, gen_next;
    logic signed [POW_W-1:0]    pow_reg, pow_next;
    logic [AW-1:0]              end_slot_reg, end_slot_next;
    logic [AW-1:0]              scan_slot_reg, scan_slot_next;
    logic signed [LEN_W-1:0]    esum_reg, esum_next;
    logic [LEN_W-1:0]           occ_reg, occ_next;
    result_t                    result_reg, result_next;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic signed [EXP_BITS-1:0] wr_exp;
    logic [AW-1:0]              rd_addr;
    logic [GEN_W-1:0]           rd_gen;
    logic signed [EXP_BITS-1:0] rd_exp;

    logic signed [EXP_BITS-1:0] unit_a;
    logic signed [POW_W-1:0]    unit_b;
    logic signed [SUM_W-1:0]    unit_sum;
    logic                       unit_fits;
    logic [EXP_BITS-1:0]        unit_mag_a;
    logic [SUM_W-1:0]           unit_mag_sum;

    logic [AW-1:0]              tail_slot;
    logic                       match;
    logic                       hit;

    function automatic logic [AW-1:0] wrap_slot(input logic [PW-1:0] s);
        logic [PW-1:0] r;
        begin
            r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
            return r[AW-1:0];
        end
    endfunction

    fgwr_run_store #(
        .DEPTH    (DEPTH),
        .EXP_BITS (EXP_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_gen  (gen_reg),
        .wr_exp  (wr_exp),
        .rd_addr (rd_addr),
        .rd_gen  (rd_gen),
        .rd_exp  (rd_exp)
    );

    fgwr_exp_unit #(
        .EXP_BITS (EXP_BITS),
        .SUM_W    (SUM_W)
    ) u_unit (
        .a       (unit_a),
        .b       (unit_b),
        .sum     (unit_sum),
        .fits    (unit_fits),
        .mag_a   (unit_mag_a),
        .mag_sum (unit_mag_sum)
    );

    always_comb
    begin
        tail_slot = (runs_reg != '0)
                  ? wrap_slot(PW'(head_reg) + PW'(runs_reg) - PW'(1))
                  : head_reg;
        match     = (runs_reg != '0) && (rd_gen == gen_reg);
        hit       = pend_reg && (rd_gen == gen_reg);

        state_next     = state_reg;
        head_next      = head_reg;
        runs_next      = runs_reg;
        total_next     = total_reg;
        scan_left_next = scan_left_reg;
        pend_next      = 1'b0;
        done_next      = 1'b0;
        op_next        = op_reg;
        gen_next       = gen_reg;
        pow_next       = pow_reg;
        end_slot_next  = end_slot_reg;
        scan_slot_next = scan_slot_reg;
        esum_next      = esum_reg;
        occ_next       = occ_reg;
        result_next    = result_reg;

        wr_en   = 1'b0;
        wr_addr = end_slot_reg;
        wr_exp  = unit_sum[EXP_BITS-1:0];
        rd_addr = scan_slot_reg;

        unit_a = match ? rd_exp : '0;
        unit_b = pow_reg;

        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (cmd.opcode == OP_PUSH_BACK) ? tail_slot : head_reg;
                if (start)
                begin
                    op_next        = cmd.opcode;
                    gen_next       = cmd.generator;
                    pow_next       = cmd.power;
                    end_slot_next  = rd_addr;
                    scan_slot_next = wrap_slot(PW'(head_reg) + PW'(1));
                    scan_left_next = (runs_reg != '0) ? (runs_reg - 1'b1) : '0;
                    esum_next      = '0;
                    occ_next       = '0;
                    if (cmd.opcode == OP_QUERY)
                    begin
                        pend_next  = (runs_reg != '0);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                result_next.status           = STAT_OK;
                result_next.exponent_sum     = '0;
                result_next.occurrence_count = '0;
                if (op_reg == OP_CLEAR)
                begin
                    head_next  = '0;
                    runs_next  = '0;
                    total_next = '0;
                end
                else if (pow_reg != '0)
                begin
                    if (!unit_fits)
                    begin
                        result_next.status = STAT_OVERFLOW;
                    end
                    else if (!match && (runs_reg == CW'(DEPTH)))
                    begin
                        result_next.status = STAT_FULL;
                    end
                    else
                    begin
                        total_next = total_reg - LEN_W'(unit_mag_a)
                                   + LEN_W'(unit_mag_sum);
                        if (match)
                        begin
                            if (unit_sum != '0)
                            begin
                                wr_en = 1'b1;
                            end
                            else
                            begin
                                runs_next = runs_reg - 1'b1;
                                if (op_reg == OP_PUSH_FRONT)
                                begin
                                    head_next = wrap_slot(PW'(head_reg) + PW'(1));
                                end
                            end
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            runs_next = runs_reg + 1'b1;
                            if (op_reg == OP_PUSH_FRONT)
                            begin
                                wr_addr   = wrap_slot(PW'(head_reg) + DEPTH_W - PW'(1));
                                head_next = wr_addr;
                            end
                            else if (runs_reg != '0)
                            begin
                                wr_addr = wrap_slot(PW'(end_slot_reg) + PW'(1));
                            end
                            else
                            begin
                                wr_addr = head_reg;
                            end
                        end
                    end
                end
                result_next.word_length = total_next;
                result_next.run_count   = CNT_W'(runs_next);
                done_next               = 1'b1;
                state_next              = ST_IDLE;
            end

            ST_SCAN:
            begin
                unit_a    = rd_exp;
                unit_b    = '0;
                esum_next = hit ? (esum_reg + LEN_W'(unit_sum)) : esum_reg;
                occ_next  = hit ? (occ_reg + LEN_W'(unit_mag_a)) : occ_reg;
                if (scan_left_reg != '0)
                begin
                    pend_next      = 1'b1;
                    scan_left_next = scan_left_reg - 1'b1;
                    scan_slot_next = wrap_slot(PW'(scan_slot_reg) + PW'(1));
                end
                else
                begin
                    result_next.status           = STAT_OK;
                    result_next.word_length      = total_reg;
                    result_next.run_count        = CNT_W'(runs_reg);
                    result_next.exponent_sum     = esum_next;
                    result_next.occurrence_count = occ_next;
                    done_next                    = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            runs_reg      <= '0;
            total_reg     <= '0;
            scan_left_reg <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            runs_reg      <= runs_next;
            total_reg     <= total_next;
            scan_left_reg <= scan_left_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        gen_reg       <= gen_next;
        pow_reg       <= pow_next;
        end_slot_reg  <= end_slot_next;
        scan_slot_reg <= scan_slot_next;
        esum_reg      <= esum_next;
        occ_reg       <= occ_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/core/fgwr_run_store.sv
// ----------------------------------------------------------------------------
// fgwr_run_store
// Run memory holding one generator and one exponent per slot, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module fgwr_run_store
    import fgwr_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEFAULT,
    parameter int EXP_BITS = EXP_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [GEN_W-1:0]            wr_gen,
    input  logic signed [EXP_BITS-1:0]  wr_exp,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [GEN_W-1:0]            rd_gen,
    output logic signed [EXP_BITS-1:0]  rd_exp
);

    logic [GEN_W-1:0]           gen_mem [DEPTH];
    logic signed [EXP_BITS-1:0] exp_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gen_mem[wr_addr] <= wr_gen;
            exp_mem[wr_addr] <= wr_exp;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_gen <= gen_mem[rd_addr];
        rd_exp <= exp_mem[rd_addr];
    end

endmodule

// File: rtl/core/fgwr_exp_unit.sv
// ----------------------------------------------------------------------------
// fgwr_exp_unit
// Shared exponent unit: adds a pushed power to a stored exponent, checks
// the sum against the exponent range and forms both magnitudes.
// ----------------------------------------------------------------------------
module fgwr_exp_unit
    import fgwr_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEFAULT,
    parameter int SUM_W    = ((EXP_BITS > POW_W) ? EXP_BITS : POW_W) + 1
)
(
    input  logic signed [EXP_BITS-1:0]  a,
    input  logic signed [POW_W-1:0]     b,
    output logic signed [SUM_W-1:0]     sum,
    output logic                        fits,
    output logic [EXP_BITS-1:0]         mag_a,
    output logic [SUM_W-1:0]            mag_sum
);

    logic signed [EXP_BITS-1:0] sum_trunc;

    always_comb
    begin
        sum       = SUM_W'(a) + SUM_W'(b);
        sum_trunc = sum[EXP_BITS-1:0];
        fits      = (sum == SUM_W'(sum_trunc));
        mag_a     = a[EXP_BITS-1] ? (~a + 1'b1) : a;
        mag_sum   = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    end

endmodule

// File: rtl/core/fgwr_checker.sv
// ----------------------------------------------------------------------------
// fgwr_checker
// Port-level checks on the reducer core: transaction sequencing and the
// contents of dropped push results.
// ----------------------------------------------------------------------------
module fgwr_checker
    import fgwr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  cmd_t    cmd,
    input  logic    done,
    input  result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Core did not turn busy after accepting a transaction.");

    a_update_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.opcode != OP_QUERY |=> ##1 done)
        else $error("Push or clear result did not appear two cycles after accept.");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobe while the core is still busy.");

    a_drop_no_query: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != STAT_OK |->
            result.exponent_sum == '0 && result.occurrence_count == '0)
        else $error("Dropped push reported nonzero query fields.");

endmodule

bind free_group_word_reducer_core fgwr_checker u_fgwr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
